// File: src/sjc_pkg.sv
// ----------------------------------------------------------------------------
// sjc_pkg
// Shared constants, types and the digit helper function of the serial joystick
// command parser.
// ----------------------------------------------------------------------------
package sjc_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int FILL_W        = $clog2(LINE_CAPACITY + 1);
    localparam int PARSE_LEN     = 17;
    localparam int BUF_IDX_W     = $clog2(PARSE_LEN);
    localparam int AXIS_LEN      = 5;
    localparam int NUM_AXES      = 4;
    localparam int NUM_CORR      = 4;
    localparam int TDATA_W       = 72;
    localparam int ADDR_W        = 3;

    localparam logic [7:0] TERM_RESET  = 8'h0A;
    localparam logic [7:0] CHAR_L      = 8'h4C;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_X      = 8'h58;
    localparam logic [7:0] CHAR_Y      = 8'h59;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;

    localparam logic REG_IDX_TERM = 1'b0;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_LEFT_X  = 3'd1,
        KIND_LEFT_Y  = 3'd2,
        KIND_RIGHT_X = 3'd3,
        KIND_RIGHT_Y = 3'd4,
        KIND_CORR    = 3'd5
    } kind_t;

    typedef logic [PARSE_LEN-1:0][7:0] line_t;

    typedef struct packed {
        logic              line_end;
        logic [FILL_W-1:0] fill;
    } buf_status_t;

    typedef struct packed {
        kind_t                      kind;
        logic [1:0]                 axis_idx;
        logic [7:0]                 axis_val;
        logic [NUM_CORR-1:0][7:0]   corr;
    } eval_t;

    function automatic logic [7:0] digit_val(input logic [7:0] ch);
        return ch - CHAR_ZERO;
    endfunction

endpackage

// File: src/serial_joystick_command_parser_top.sv
// ----------------------------------------------------------------------------
// serial_joystick_command_parser_top
// Parses received serial bytes into joystick axis values and motor
// corrections.
//
// Each byte enters on the s_ stream and produces exactly one beat on the m_
// stream. That beat carries the line end flag on m_tlast, the update kind on
// m_tuser and the current axis values and corrections on m_tdata.
// A byte is held in an input register and is parsed in the cycle it moves
// to the output register that presents the result beat. One byte is
// accepted every cycle while the receiver keeps up; the single-pass parse
// of fixed buffer positions sets that rate.
// When the receiver stalls, the output beat holds, the input register fills
// and s_tready drops until the output beat is taken.
// Reset clears the line, all axis values and corrections, and sets the line
// terminator to newline. The user must write the terminator on the APB port
// at address 0 only while no byte is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module serial_joystick_command_parser_top
    import sjc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Received bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    // Parse results
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [0] active, [8:1] left_x, [16:9] left_y,
                                          // [24:17] right_x, [32:25] right_y,
                                          // [40:33] correction_a, [48:41] correction_b,
                                          // [56:49] correction_c, [64:57] correction_d
    output logic               m_tlast,   // line_end
    output logic [2:0]         m_tuser    // update_kind
);

    logic [7:0]                term_reg;
    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      out_valid_reg;
    logic                      out_end_reg;
    kind_t                     out_kind_reg;
    logic                      out_active_reg;
    logic [NUM_AXES-1:0][7:0]  axis_reg;
    logic [NUM_AXES-1:0][7:0]  axis_next;
    logic [NUM_CORR-1:0][7:0]  corr_reg;
    logic [NUM_CORR-1:0][7:0]  corr_next;
    logic                      step;
    logic                      cfg_write;
    line_t                     line;
    buf_status_t               status;
    eval_t                     ev;
    kind_t                     kind;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_TERM);
    assign prdata    = (paddr[2] == REG_IDX_TERM) ? {24'd0, term_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (cfg_write) begin
            term_reg <= pwdata[7:0];
        end
    end

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    sjc_line_buf u_line_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .rx_byte    (in_byte_reg),
        .terminator (term_reg),
        .line       (line),
        .status     (status)
    );

    sjc_eval u_eval (
        .line   (line),
        .fill   (status.fill),
        .result (ev)
    );

    always_comb begin
        kind      = status.line_end ? ev.kind : KIND_NONE;
        axis_next = axis_reg;
        corr_next = corr_reg;
        case (kind) inside
            KIND_LEFT_X, KIND_LEFT_Y, KIND_RIGHT_X, KIND_RIGHT_Y: begin
                axis_next[ev.axis_idx] = ev.axis_val;
            end
            KIND_CORR: begin
                corr_next = ev.corr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg       <= '0;
            corr_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_active_reg <= 1'b0;
        end else begin
            if (step) begin
                axis_reg       <= axis_next;
                corr_reg       <= corr_next;
                out_active_reg <= 1'b1;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_end_reg  <= status.line_end;
            out_kind_reg <= kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, corr_reg[3], corr_reg[2], corr_reg[1], corr_reg[0],
                       axis_reg[3], axis_reg[2], axis_reg[1], axis_reg[0], out_active_reg};

    a_kind_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_NONE) |-> m_tlast)
        else $error("update kind reported without a line end");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.fill <= FILL_W'(LINE_CAPACITY))
        else $error("line fill count exceeds capacity");

    a_end_clears_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        step && status.line_end |=> status.fill == '0)
        else $error("line buffer not emptied at line end");

    a_active_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0])
        else $error("result beat without active flag");

endmodule

// File: src/sjc_line_buf.sv
// ----------------------------------------------------------------------------
// sjc_line_buf
// Collects received bytes of the current line and detects the line end.
// Only the leading positions that the line formats use are stored.
// ----------------------------------------------------------------------------
module sjc_line_buf
    import sjc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  terminator,
    output line_t       line,
    output buf_status_t status
);

    logic [7:0]        buf_reg [PARSE_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              line_end;

    assign line_end = (rx_byte == terminator) || (fill_reg == FILL_W'(LINE_CAPACITY));

    always_comb begin
        fill_next = fill_reg;
        if (step) begin
            if (line_end) begin
                fill_next = '0;
            end else begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && !line_end && fill_reg < FILL_W'(PARSE_LEN)) begin
            buf_reg[fill_reg[BUF_IDX_W-1:0]] <= rx_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < PARSE_LEN; i++) begin
            line[i] = buf_reg[i];
        end
    end

    assign status.line_end = line_end;
    assign status.fill     = fill_reg;

endmodule

// File: src/sjc_eval.sv
// ----------------------------------------------------------------------------
// sjc_eval
// Decodes a buffered line into an axis update or a set of motor corrections.
// ----------------------------------------------------------------------------
module sjc_eval
    import sjc_pkg::*;
(
    input  line_t             line,
    input  logic [FILL_W-1:0] fill,
    output eval_t             result
);

    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic       is_left;
    logic       is_right;
    logic       is_x;
    logic       is_y;
    logic [7:0] mag [NUM_CORR];

    assign d0 = digit_val(line[2]);
    assign d1 = digit_val(line[3]);
    assign d2 = digit_val(line[4]);

    assign is_left  = (line[0] == CHAR_L);
    assign is_right = (line[0] == CHAR_R);
    assign is_x     = (line[1] == CHAR_X);
    assign is_y     = (line[1] == CHAR_Y);

    always_comb begin
        for (int k = 0; k < NUM_CORR; k++) begin
            mag[k] = 8'(digit_val(line[4*k+2]) * 8'd10) + digit_val(line[4*k+3]);
            if (line[4*k+1] == CHAR_N) begin
                result.corr[k] = 8'd0 - mag[k];
            end else begin
                result.corr[k] = mag[k];
            end
        end
    end

    assign result.axis_val = 8'(d0 * 8'd100) + 8'(d1 * 8'd10) + d2;
    assign result.axis_idx = {is_right, is_y};

    always_comb begin
        result.kind = KIND_NONE;
        if (fill == FILL_W'(AXIS_LEN)) begin
            if (is_left && is_x) begin
                result.kind = KIND_LEFT_X;
            end else if (is_left && is_y) begin
                result.kind = KIND_LEFT_Y;
            end else if (is_right && is_x) begin
                result.kind = KIND_RIGHT_X;
            end else if (is_right && is_y) begin
                result.kind = KIND_RIGHT_Y;
            end
        end else if (fill == FILL_W'(PARSE_LEN) && line[PARSE_LEN-1] == CHAR_S) begin
            result.kind = KIND_CORR;
        end
    end

endmodule
